### rtl/aosc_pkg.sv
`timescale 1ns / 1ps
package aosc_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW  = 3'd1;
  localparam logic [2:0] REG_IV_HIGH  = 3'd2;
  localparam logic [2:0] REG_IV_LOW   = 3'd3;
  localparam logic [2:0] REG_SEG      = 3'd4;

  localparam int          BLOCK_BYTES = 16;
  localparam int          AES_ROUNDS  = 10;
  localparam logic [4:0]  SEG_RESET   = 5'd16;

  // One input beat as it travels from the front queue to the back end.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
    logic       final_byte;
  } item_t;

  // Status of the cipher core as seen by the back end.
  typedef struct packed {
    logic busy;
    logic done;
  } aes_status_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [AES_ROUNDS] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    xtime = {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // One full round without the key addition; the last round skips the column mix.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[j + 4 * c] = SBOX[s[127 - 8 * (j + 4 * ((c + j) % 4)) -: 8]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4 * c];
      a1 = t[4 * c + 1];
      a2 = t[4 * c + 2];
      a3 = t[4 * c + 3];
      all = a0 ^ a1 ^ a2 ^ a3;
      if (last) begin
        r[127 - 32 * c -: 32] = {a0, a1, a2, a3};
      end else begin
        r[127 - 32 * c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                 a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
      end
    end
    aes_round = r;
  endfunction

  // Next round key from the current one.
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tmp;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ tmp;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    key_next = {w0, w1, w2, w3};
  endfunction

endpackage

### rtl/aes128_ofb_segment_cipher_core.sv
`timescale 1ns / 1ps
// AES-128 output feedback cipher with segment feedback, one byte per beat.
// Within a segment a byte passes every cycle while input waits and the output
// is not stalled. At the start of each segment (after reset, after a segment
// closes, or on a restart beat) the iterative AES core encrypts the feedback
// register (on a restart beat the IV), one round per cycle; the first byte of
// the segment waits for that block. A two-beat input queue takes beats while
// it has room, even as the cipher runs or the output stalls. Registers sit
// at byte addresses 8*i: key high, key low, IV high, IV low, segment length.
module aes128_ofb_segment_cipher_core
  import aosc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        restart,
  input  logic        final_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  result_byte,
  output logic        final_out
);

  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [63:0] iv_high;
  logic [63:0] iv_low;
  logic [4:0]  segment_bytes;
  logic [2:0]  reg_idx;
  logic        wr_en;
  logic        head_valid;
  item_t       head;
  logic        pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign wr_en   = psel && penable && pwrite && pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high      <= '0;
      key_low       <= '0;
      iv_high       <= '0;
      iv_low        <= '0;
      segment_bytes <= SEG_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_KEY_HIGH: key_high      <= pwdata;
        REG_KEY_LOW:  key_low       <= pwdata;
        REG_IV_HIGH:  iv_high       <= pwdata;
        REG_IV_LOW:   iv_low        <= pwdata;
        REG_SEG:      segment_bytes <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_KEY_HIGH: prdata = key_high;
      REG_KEY_LOW:  prdata = key_low;
      REG_IV_HIGH:  prdata = iv_high;
      REG_IV_LOW:   prdata = iv_low;
      REG_SEG:      prdata = {59'd0, segment_bytes};
      default:      prdata = '0;
    endcase
  end

  aosc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_byte (data_byte),
    .restart   (restart),
    .final_byte(final_byte),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop)
  );

  aosc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .key          ({key_high, key_low}),
    .iv           ({iv_high, iv_low}),
    .segment_bytes(segment_bytes),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_byte  (result_byte),
    .final_out    (final_out)
  );

endmodule

### rtl/aosc_front.sv
`timescale 1ns / 1ps
module aosc_front
  import aosc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       restart,
  input  logic       final_byte,
  output logic       head_valid,
  output item_t      head,
  input  logic       pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;

  // The queue takes a beat whenever it has room, independent of the back end.
  assign in_stall   = (count == 2'd2);
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != 2'd0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{data_byte: data_byte, restart: restart, final_byte: final_byte};
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/aosc_aes.sv
`timescale 1ns / 1ps
module aosc_aes
  import aosc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] block_in,
  input  logic [127:0] key,
  output aes_status_t  status,
  output logic [127:0] block_out
);

  logic         running;
  logic         done;
  logic [3:0]   rnd;
  logic [127:0] st;
  logic [127:0] rk;
  logic [127:0] rk_next;
  logic         last;

  assign last      = (rnd == 4'(AES_ROUNDS));
  assign rk_next   = key_next(rk, RCON[rnd - 4'd1]);
  assign status    = '{busy: running, done: done};
  assign block_out = st;

  // Payload: one round per cycle, round key expanded alongside.
  always_ff @(posedge clk) begin
    if (start) begin
      st  <= block_in ^ key;
      rk  <= key;
    end else if (running) begin
      st  <= aes_round(st, last) ^ rk_next;
      rk  <= rk_next;
    end
  end

  // Round sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      rnd     <= 4'd1;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        rnd     <= 4'd1;
      end else if (running) begin
        rnd <= rnd + 4'd1;
        if (last) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/aosc_back.sv
`timescale 1ns / 1ps
module aosc_back
  import aosc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         head_valid,
  input  item_t        head,
  output logic         pop,
  input  logic [127:0] key,
  input  logic [127:0] iv,
  input  logic [4:0]   segment_bytes,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   result_byte,
  output logic         final_out
);

  logic [127:0] fb;
  logic [127:0] ks;
  logic [3:0]   pos;
  logic         fresh;
  logic [127:0] fb_eff;
  logic         need_ks;
  logic         out_free;
  logic         launch;
  logic         emit;
  logic [4:0]   used;
  logic [4:0]   seg_eff;
  logic         close;
  logic [127:0] fb_closed;
  logic [7:0]   ks_byte;
  aes_status_t  aes_st;
  logic [127:0] aes_out;

  aosc_aes u_aes (
    .clk      (clk),
    .rst      (rst),
    .start    (launch),
    .block_in (fb_eff),
    .key      (key),
    .status   (aes_st),
    .block_out(aes_out)
  );

  // Segment length after clamping to one through sixteen.
  always_comb begin
    if (segment_bytes == 5'd0) begin
      seg_eff = 5'd1;
    end else if (segment_bytes > 5'd16) begin
      seg_eff = 5'd16;
    end else begin
      seg_eff = segment_bytes;
    end
  end

  // A beat needs a fresh keystream block when it restarts or opens a segment.
  assign fb_eff   = head.restart ? iv : fb;
  assign need_ks  = head.restart || (pos == 4'd0);
  assign out_free = !out_valid || !out_stall;
  assign launch   = head_valid && need_ks && !fresh && !aes_st.busy && !aes_st.done;
  assign emit     = head_valid && (fresh || !need_ks) && out_free;
  assign pop      = emit;

  assign used      = {1'b0, pos} + 5'd1;
  assign close     = (used >= seg_eff) || head.final_byte;
  assign ks_byte   = ks[8'd127 - {pos, 3'b000} -: 8];
  assign fb_closed = (fb << {used, 3'b000}) | (ks >> {5'd16 - used, 3'b000});

  // Feedback register, keystream block and byte position.
  always_ff @(posedge clk) begin
    if (rst) begin
      fb    <= '0;
      ks    <= '0;
      pos   <= 4'd0;
      fresh <= 1'b0;
    end else begin
      if (launch) begin
        fb  <= fb_eff;
        pos <= 4'd0;
      end
      if (aes_st.done) begin
        ks    <= aes_out;
        fresh <= 1'b1;
      end
      if (emit) begin
        fresh <= 1'b0;
        if (close) begin
          fb  <= fb_closed;
          pos <= 4'd0;
        end else begin
          pos <= used[3:0];
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_byte <= head.data_byte ^ ks_byte;
      final_out   <= head.final_byte;
    end
  end

  a_fresh_at_start: assert property (@(posedge clk) disable iff (rst)
    fresh |-> (pos == 4'd0))
    else $error("fresh keystream while mid-segment");
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    aes_st.done |-> !fresh)
    else $error("cipher finished while a fresh block was still unused");
  a_launch_idle: assert property (@(posedge clk) disable iff (rst)
    launch |-> !aes_st.busy && !emit)
    else $error("cipher launched while busy or alongside a beat");
  a_close_resets: assert property (@(posedge clk) disable iff (rst)
    emit && close |=> (pos == 4'd0))
    else $error("segment closed but position not cleared");

endmodule
